[src/mlfc_pkg.sv]
// ----------------------------------------------------------------------------
// mlfc_pkg
// Shared types and constants for the motion light fade controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfc_pkg;

    // Event codes
    typedef enum logic [1:0] {
        OP_MS_TICK  = 2'd0,
        OP_MOTION   = 2'd1,
        OP_IR_KEY   = 2'd2,
        OP_SEC_TICK = 2'd3
    } opcode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FADE_STEP = 2'd0,
        CFG_OFF_DELAY = 2'd1,
        CFG_DUSK      = 2'd2
    } cfg_index_t;

    localparam int CFG_DATA_W  = 16;
    localparam int DELAY_W     = 26;
    localparam int TBL_IDX_W   = 5;

    localparam logic [31:0] KEY_POWER  = 32'd284151855;
    localparam logic [31:0] KEY_AUTO   = 32'd284125335;
    localparam logic [31:0] KEY_MANUAL = 32'd284125845;

    localparam logic [9:0] MS_PER_S = 10'd1000;

    localparam logic [7:0]         FADE_STEP_RST = 8'd35;
    localparam logic [15:0]        OFF_DELAY_RST = 16'd20;
    localparam logic [DELAY_W-1:0] DELAY_LIM_RST = 26'd20000;

    typedef struct packed {
        opcode_t     opcode;
        logic        motion_level;
        logic [31:0] key_code;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  light_level;
        logic        auto_on;
        logic        motion_seen;
        logic        fade_busy;
        logic [15:0] secs_to_off;
        logic [15:0] secs_with_motion;
    } out_item_t;

    // Brightness curve; entries past the end read full scale
    function automatic logic [7:0] level_at(input logic [TBL_IDX_W-1:0] idx);
        logic [7:0] lvl;
        case (idx)
            5'd0:    lvl = 8'd0;
            5'd1:    lvl = 8'd1;
            5'd2:    lvl = 8'd2;
            5'd3:    lvl = 8'd3;
            5'd4:    lvl = 8'd4;
            5'd5:    lvl = 8'd6;
            5'd6:    lvl = 8'd8;
            5'd7:    lvl = 8'd12;
            5'd8:    lvl = 8'd16;
            5'd9:    lvl = 8'd22;
            5'd10:   lvl = 8'd29;
            5'd11:   lvl = 8'd39;
            5'd12:   lvl = 8'd51;
            5'd13:   lvl = 8'd67;
            5'd14:   lvl = 8'd86;
            5'd15:   lvl = 8'd109;
            5'd16:   lvl = 8'd136;
            5'd17:   lvl = 8'd170;
            5'd18:   lvl = 8'd209;
            default: lvl = 8'd255;
        endcase
        return lvl;
    endfunction

endpackage

`default_nettype wire

[src/motion_light_fade_controller.sv]
// Each input transfer's result is in the output register in the cycle after the transfer.
// Throughput: one event per cycle while results are taken; a stalled result
//   holds the input until it drains, then the next event enters that same edge.
// Reset (rst_n low, async): all state but the result payload to its idle values, light off, auto mode on,
//   config registers to 35 ms step, 20 s delay, dusk flag set; no result pending.
// ----------------------------------------------------------------------------
// motion_light_fade_controller
// Motion-activated light with table-driven fade up/down, one-shot off delay,
// IR key handling and saturating second counters.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_light_fade_controller
    import mlfc_pkg::*;
#(
    parameter int FADE_STEPS = 20
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // event channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    // config write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (FADE_STEPS > 1) ? $clog2(FADE_STEPS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FADE_STEPS - 1);

    // ------------------------------------------------------------------
    // Config registers. The delay limit in ms is formed at write time so
    // the tick path only compares.
    // ------------------------------------------------------------------
    logic [7:0]         fade_step_reg;
    logic [15:0]        off_delay_reg;
    logic [DELAY_W-1:0] delay_lim_reg;
    logic               dusk_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_step_reg <= FADE_STEP_RST;
            off_delay_reg <= OFF_DELAY_RST;
            delay_lim_reg <= DELAY_LIM_RST;
            dusk_reg      <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_FADE_STEP: fade_step_reg <= cfg_data[7:0];
                CFG_OFF_DELAY:
                begin
                    off_delay_reg <= cfg_data;
                    delay_lim_reg <= DELAY_W'(cfg_data) * DELAY_W'(MS_PER_S);
                end
                CFG_DUSK:      dusk_reg <= cfg_data[0];
                default:       ;  // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: one result register. A new event enters whenever the
    // result register is empty or is being taken this cycle.
    // ------------------------------------------------------------------
    logic accept;
    logic out_valid_reg;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    logic               motion_reg,     motion_next;
    logic               fading_reg,     fading_next;
    logic               fade_up_reg,    fade_up_next;
    logic [IDX_W-1:0]   step_idx_reg,   step_idx_next;
    logic [7:0]         step_timer_reg, step_timer_next;
    logic               delay_arm_reg,  delay_arm_next;
    logic [DELAY_W-1:0] delay_tmr_reg,  delay_tmr_next;
    logic [7:0]         duty_reg,       duty_next;
    logic               auto_reg,       auto_next;
    logic               manual_reg,     manual_next;
    logic [15:0]        countdown_reg,  countdown_next;
    logic [15:0]        motion_s_reg,   motion_s_next;

    logic [7:0]         period;
    logic [7:0]         step_timer_inc;
    logic [DELAY_W-1:0] delay_tmr_inc;

    // a zero fade period behaves as one ms
    assign period         = (fade_step_reg == 8'd0) ? 8'd1 : fade_step_reg;
    assign step_timer_inc = step_timer_reg + 8'd1;
    assign delay_tmr_inc  = delay_tmr_reg + DELAY_W'(1);

    always_comb
    begin
        motion_next     = motion_reg;
        fading_next     = fading_reg;
        fade_up_next    = fade_up_reg;
        step_idx_next   = step_idx_reg;
        step_timer_next = step_timer_reg;
        delay_arm_next  = delay_arm_reg;
        delay_tmr_next  = delay_tmr_reg;
        duty_next       = duty_reg;
        auto_next       = auto_reg;
        manual_next     = manual_reg;
        countdown_next  = countdown_reg;
        motion_s_next   = motion_s_reg;

        case (in_data.opcode)
            OP_MS_TICK:
            begin
                // fade is served first, then the off delay
                if (fading_reg)
                begin
                    step_timer_next = step_timer_inc;
                    if (step_timer_inc >= period)
                    begin
                        step_timer_next = 8'd0;
                        duty_next       = level_at(TBL_IDX_W'(step_idx_reg));
                        if (fade_up_reg)
                        begin
                            if (step_idx_reg >= LAST_IDX)
                            begin
                                fading_next    = 1'b0;
                                countdown_next = 16'd0;
                            end
                            else
                            begin
                                step_idx_next = step_idx_reg + IDX_W'(1);
                            end
                        end
                        else
                        begin
                            if (step_idx_reg == '0)
                            begin
                                fading_next    = 1'b0;
                                countdown_next = 16'd0;
                            end
                            else
                            begin
                                step_idx_next = step_idx_reg - IDX_W'(1);
                            end
                        end
                    end
                end
                if (delay_arm_reg)
                begin
                    delay_tmr_next = delay_tmr_inc;
                    if (delay_tmr_inc >= delay_lim_reg)
                    begin
                        delay_arm_next = 1'b0;
                        if (!motion_reg && duty_next != 8'd0)
                        begin
                            manual_next = 1'b0;
                            if (!fading_next)
                            begin
                                fading_next     = 1'b1;
                                fade_up_next    = 1'b0;
                                step_idx_next   = LAST_IDX;
                                step_timer_next = 8'd0;
                            end
                        end
                    end
                end
            end

            OP_MOTION:
            begin
                if (in_data.motion_level != motion_reg)
                begin
                    motion_next = in_data.motion_level;
                    if (!in_data.motion_level)
                    begin
                        countdown_next = off_delay_reg;
                        motion_s_next  = 16'd0;
                        if (auto_reg)
                        begin
                            delay_tmr_next = '0;
                            delay_arm_next = 1'b1;
                        end
                    end
                    else if (auto_reg && (dusk_reg || manual_reg) && duty_reg == 8'd0)
                    begin
                        motion_s_next = 16'd0;
                        if (!fading_reg)
                        begin
                            delay_arm_next  = 1'b0;
                            fading_next     = 1'b1;
                            fade_up_next    = 1'b1;
                            step_idx_next   = '0;
                            step_timer_next = 8'd0;
                        end
                    end
                end
            end

            OP_IR_KEY:
            begin
                if (in_data.key_code == KEY_POWER)
                begin
                    duty_next = 8'd0;
                end
                else if (in_data.key_code == KEY_AUTO)
                begin
                    auto_next = !auto_reg;
                end
                else if (in_data.key_code == KEY_MANUAL)
                begin
                    manual_next = !dusk_reg && auto_reg && duty_reg == 8'd0;
                end
            end

            OP_SEC_TICK:
            begin
                if (!motion_reg)
                begin
                    if (countdown_reg != 16'd0)
                        countdown_next = countdown_reg - 16'd1;
                end
                else if (motion_s_reg != 16'hFFFF)
                begin
                    motion_s_next = motion_s_reg + 16'd1;
                end
            end

            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_reg     <= 1'b0;
            fading_reg     <= 1'b0;
            fade_up_reg    <= 1'b1;
            step_idx_reg   <= '0;
            step_timer_reg <= 8'd0;
            delay_arm_reg  <= 1'b0;
            delay_tmr_reg  <= '0;
            duty_reg       <= 8'd0;
            auto_reg       <= 1'b1;
            manual_reg     <= 1'b0;
            countdown_reg  <= 16'd0;
            motion_s_reg   <= 16'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                motion_reg     <= motion_next;
                fading_reg     <= fading_next;
                fade_up_reg    <= fade_up_next;
                step_idx_reg   <= step_idx_next;
                step_timer_reg <= step_timer_next;
                delay_arm_reg  <= delay_arm_next;
                delay_tmr_reg  <= delay_tmr_next;
                duty_reg       <= duty_next;
                auto_reg       <= auto_next;
                manual_reg     <= manual_next;
                countdown_reg  <= countdown_next;
                motion_s_reg   <= motion_s_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload: the state after the event
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data.light_level      <= duty_next;
            out_data.auto_on          <= auto_next;
            out_data.motion_seen      <= motion_next;
            out_data.fade_busy        <= fading_next;
            out_data.secs_to_off      <= countdown_next;
            out_data.secs_with_motion <= motion_s_next;
        end
    end

`ifndef SYNTHESIS
    // a stall on the input only comes from a held result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending result");

    // every accepted event leaves a result
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted event produced no result");

    // the light level moves only on an event
    a_duty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(duty_reg))
        else $error("duty changed without an event");

    // fade index stays within the curve
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_idx_reg <= LAST_IDX)
        else $error("fade step index out of range");
`endif

endmodule

`default_nettype wire
